[src/aqp_pkg.sv]
`timescale 1ns / 1ps
// Package for the aging priority queue: word types, codes and command struct.
package aqp_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_RETRIEVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BADPRIO = 2'd3
  } status_e;

  typedef struct packed {
    op_e                opcode;
    logic [ID_W-1:0]    entry_id;
    logic [PRIO_W-1:0]  entry_priority;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    retrieved_id;
    logic [OCC_W-1:0]   occupancy;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming word
    logic exec;  // apply the captured word and load the result register
  } cmd_t;

endpackage

[src/aging_priority_queue.sv]
`timescale 1ns / 1ps
// Top level of the aging priority queue: controller and datapath.
//
// Usage
//   Input channel (in_valid_i / in_ready_o / in_word_i): one word per command,
//   opcode insert with an id and a priority, or retrieve of the head entry.
//   Output channel (out_valid_o / out_ready_i / out_word_o): exactly one word
//   per command with a status, the retrieved id (zero unless a retrieve
//   succeeded) and the number of entries held afterwards.
//   Entries are kept sorted by ascending priority, ties in arrival order. A
//   retrieve pops the head and ages every remaining entry down by one, never
//   below one. Bad priorities, full inserts and empty retrieves are rejected
//   with a status code and leave the queue unchanged.
//   A word is captured in the input register and executes into the result
//   register once that is free; the sorted slot row is updated in the same
//   step (one compare per slot); the next word is accepted after execution.
//   A new word is accepted while a finished result still waits; execution
//   then holds until the result register is read.
//   Reset empties the queue; slot contents are not cleared.
module aging_priority_queue #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned ID_BITS      = 16,
  parameter int unsigned PRIORITY_MAX = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  aqp_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output aqp_pkg::out_word_t out_word_o
);
  import aqp_pkg::*;

  cmd_t cmd;

  // Sequence each word: capture, then execute once the result register is free.
  aqp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold the sorted slot row, the entry count and the result word.
  aqp_dp #(
    .DEPTH        (DEPTH),
    .ID_BITS      (ID_BITS),
    .PRIORITY_MAX (PRIORITY_MAX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

[src/aqp_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the aging priority queue: handshake and sequencing state machine.
module aqp_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output aqp_pkg::cmd_t cmd_o
);
  import aqp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait for room in the result register
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("result register not loaded after execution");

  a_blocked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && out_valid_q && !out_ready_i) |=> (state_q == ST_EXEC))
    else $error("pending word executed over an unread result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> out_free)
    else $error("execution while result register is full");

endmodule

[src/aqp_dp.sv]
`timescale 1ns / 1ps
// Datapath of the aging priority queue: input register, sorted slot row, result register.
module aqp_dp #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned ID_BITS      = 16,
  parameter int unsigned PRIORITY_MAX = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aqp_pkg::cmd_t      cmd_i,
  input  aqp_pkg::in_word_t  in_word_i,
  output aqp_pkg::out_word_t out_word_o
);
  import aqp_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDS_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam logic [15:0] PRIO_LIMIT = 16'(PRIORITY_MAX);

  in_word_t           in_q;
  out_word_t          out_q;
  logic [CNT_W-1:0]   count_q, count_d;

  logic [IDS_W-1:0]   slot_id_q   [DEPTH];
  logic [IDS_W-1:0]   slot_id_d   [DEPTH];
  logic [PRIO_W-1:0]  slot_prio_q [DEPTH];
  logic [PRIO_W-1:0]  slot_prio_d [DEPTH];

  logic [DEPTH-1:0]   gt;
  logic [DEPTH-1:0]   gt_below;
  logic               is_ins, prio_ok, full, empty, do_ins, do_ret;
  status_e            status;

  assign is_ins  = (in_q.opcode == OP_INSERT);
  assign prio_ok = (in_q.entry_priority != '0) && (16'(in_q.entry_priority) <= PRIO_LIMIT);
  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign do_ins  = is_ins && prio_ok && !full;
  assign do_ret  = !is_ins && !empty;

  always_comb begin
    if (is_ins && !prio_ok) begin
      status = ST_BADPRIO;
    end else if (is_ins && full) begin
      status = ST_FULL;
    end else if (!is_ins && empty) begin
      status = ST_EMPTY;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_ret) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  // Slot i moves behind the new entry when it is empty or ranks strictly after it.
  assign gt_below = {gt[DEPTH-2:0], 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    assign gt[i] = (CNT_W'(i) >= count_q) || (slot_prio_q[i] > in_q.entry_priority);

    if (i < DEPTH - 1) begin : g_mid
      always_comb begin
        slot_id_d[i]   = slot_id_q[i];
        slot_prio_d[i] = slot_prio_q[i];
        if (do_ins && gt[i]) begin
          if (gt_below[i]) begin
            slot_id_d[i]   = slot_id_q[i-1 < 0 ? 0 : i-1];
            slot_prio_d[i] = slot_prio_q[i-1 < 0 ? 0 : i-1];
          end else begin
            slot_id_d[i]   = in_q.entry_id[IDS_W-1:0];
            slot_prio_d[i] = in_q.entry_priority;
          end
        end else if (do_ret) begin
          // advance and age, floor of one
          slot_id_d[i]   = slot_id_q[i+1];
          slot_prio_d[i] = (slot_prio_q[i+1] > PRIO_W'(1)) ? slot_prio_q[i+1] - 1'b1
                                                           : slot_prio_q[i+1];
        end
      end
    end else begin : g_last
      always_comb begin
        slot_id_d[i]   = slot_id_q[i];
        slot_prio_d[i] = slot_prio_q[i];
        if (do_ins && gt[i]) begin
          if (gt_below[i]) begin
            slot_id_d[i]   = slot_id_q[i-1];
            slot_prio_d[i] = slot_prio_q[i-1];
          end else begin
            slot_id_d[i]   = in_q.entry_id[IDS_W-1:0];
            slot_prio_d[i] = in_q.entry_priority;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_word_i;
    end
    if (cmd_i.exec) begin
      slot_id_q              <= slot_id_d;
      slot_prio_q            <= slot_prio_d;
      out_q.status           <= status;
      out_q.retrieved_id     <= do_ret ? ID_W'(slot_id_q[0]) : '0;
      out_q.occupancy        <= OCC_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign out_word_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_retrieve_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && do_ret) |=> (count_q == CNT_W'($past(count_q) - 1'b1)))
    else $error("retrieve did not drop one entry");

  a_reject_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && status != ST_OK) |=> $stable(count_q))
    else $error("rejected word changed the entry count");

endmodule
